// File: sv/dirf_pkg.sv
`default_nettype none

package dirf_pkg;

  localparam int unsigned DEPTH_DEF  = 1024;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned MID_W      = 32;
  localparam int unsigned EID_W      = 16;
  localparam int unsigned HS_W       = 11;
  localparam int unsigned OUT_SLOT_W = 10;

  // One search token walking down the row of cells.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [KEY_W-1:0] key;
  } token_t;

endpackage

`default_nettype wire

// File: sv/dirf_cell.sv
`default_nettype none

module dirf_cell import dirf_pkg::*; #(
  parameter  int unsigned DEPTH  = DEPTH_DEF,
  parameter  int unsigned IDX    = 0,
  localparam int unsigned SLOT_W = $clog2(DEPTH),
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1)
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire token_t       tok_i,
  output token_t            tok_o,
  input  wire [CNT_W-1:0]   size_i,
  input  wire [SLOT_W-1:0]  fill_i,
  input  wire               wr_en_i,
  input  wire [SLOT_W-1:0]  wr_slot_i,
  input  wire [KEY_W-1:0]   wr_key_i
);

  logic [KEY_W-1:0] key_q;
  logic             tok_valid_q;
  logic             tok_hit_q;
  logic [KEY_W-1:0] tok_key_q;
  logic             active;
  logic             written;
  logic [KEY_W-1:0] stored;
  logic             match;

  // Slots above the fill mark were never written; they read as zero.
  assign active  = (IDX != 0) && (CNT_W'(IDX) < size_i);
  assign written = (SLOT_W'(IDX) <= fill_i);
  assign stored  = written ? key_q : '0;
  assign match   = active && (stored == tok_i.key);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_slot_i == SLOT_W'(IDX))) begin
      key_q <= wr_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_hit_q <= tok_i.hit | match;
    tok_key_q <= tok_i.key;
  end

  assign tok_o = '{valid: tok_valid_q, hit: tok_hit_q, key: tok_key_q};

endmodule

`default_nettype wire

// File: sv/dirf_ctrl.sv
`default_nettype none

module dirf_ctrl import dirf_pkg::*; #(
  parameter  int unsigned DEPTH  = DEPTH_DEF,
  localparam int unsigned SLOT_W = $clog2(DEPTH),
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire [MID_W-1:0]       message_id_i,
  input  wire [EID_W-1:0]       echo_id_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic                  is_duplicate_o,
  output logic [OUT_SLOT_W-1:0] stored_slot_o,
  input  wire                   cfg_we_i,
  input  wire [HS_W-1:0]        cfg_wdata_i,
  output token_t                tok_launch_o,
  input  wire token_t           tok_done_i,
  output logic [CNT_W-1:0]      size_o,
  output logic [SLOT_W-1:0]     fill_o,
  output logic                  wr_en_o,
  output logic [SLOT_W-1:0]     wr_slot_o,
  output logic [KEY_W-1:0]      wr_key_o
);

  localparam int unsigned HS_MAX   = (1 << HS_W) - 1;
  localparam int unsigned HS_RESET = (DEPTH > HS_MAX) ? HS_MAX : DEPTH;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LAUNCH = 4'b0010,
    S_SEARCH = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [HS_W-1:0]         hsize_q;
  logic [SLOT_W-1:0]       ptr_q, ptr_d;
  logic [SLOT_W-1:0]       fill_q, fill_d;
  logic                    out_valid_q, out_valid_d;
  logic                    dup_q;
  logic [OUT_SLOT_W-1:0]   slot_out_q;
  logic [KEY_W-1:0]        key_q;
  logic                    hit_q;
  logic [KEY_W-1:0]        product;
  logic [CNT_W-1:0]        next_slot;
  logic [SLOT_W-1:0]       slot;
  logic                    load_out;

  assign product = KEY_W'(message_id_i * echo_id_i);

  // Sizes above the store depth saturate to the depth.
  assign size_o = (32'(hsize_q) > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(hsize_q);

  // The ring wraps back to slot 1; slot 0 is never used.
  assign next_slot = CNT_W'(ptr_q) + CNT_W'(1);
  assign slot      = (next_slot >= size_o) ? SLOT_W'(1) : SLOT_W'(next_slot);

  assign load_out = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (tok_done_i.valid) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (!hit_q) begin
            ptr_d = slot;
            if (slot > fill_q) begin
              fill_d = slot;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hsize_q     <= HS_W'(HS_RESET);
      ptr_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        hsize_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      key_q <= product;
    end
    if ((state_q == S_SEARCH) && tok_done_i.valid) begin
      hit_q <= tok_done_i.hit;
    end
    if (load_out) begin
      dup_q      <= hit_q;
      slot_out_q <= hit_q ? '0 : OUT_SLOT_W'(slot);
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign is_duplicate_o = dup_q;
  assign stored_slot_o  = slot_out_q;

  assign tok_launch_o = '{valid: (state_q == S_LAUNCH), hit: 1'b0, key: key_q};

  assign fill_o    = fill_q;
  assign wr_en_o   = load_out && !hit_q;
  assign wr_slot_o = slot;
  assign wr_key_o  = key_q;

endmodule

`default_nettype wire

// File: sv/duplicate_id_ring_filter.sv
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o     message_id_i, echo_id_i
// out      output     out_valid_o / out_ready_i   is_duplicate_o, stored_slot_o
// cfg      input      cfg_we_i                    cfg_wdata_i (history size)
//
// From its input transfer an item goes through launch, search and finish until
// its result is offered; the search token walks the DEPTH cells at one cell per cycle.
// Items are taken one at a time; the next input transfer can happen while a
// result still waits in the output register.
// Reset needs no clearing pass: a fill mark tells which slots still read zero.

module duplicate_id_ring_filter import dirf_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire [MID_W-1:0]       message_id_i,
  input  wire [EID_W-1:0]       echo_id_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic                  is_duplicate_o,
  output logic [OUT_SLOT_W-1:0] stored_slot_o,
  input  wire                   cfg_we_i,
  input  wire [HS_W-1:0]        cfg_wdata_i
);

  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  token_t             tok [DEPTH+1];
  logic [CNT_W-1:0]   size;
  logic [SLOT_W-1:0]  fill;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_slot;
  logic [KEY_W-1:0]   wr_key;

  dirf_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .message_id_i   (message_id_i),
    .echo_id_i      (echo_id_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .is_duplicate_o (is_duplicate_o),
    .stored_slot_o  (stored_slot_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .tok_launch_o   (tok[0]),
    .tok_done_i     (tok[DEPTH]),
    .size_o         (size),
    .fill_o         (fill),
    .wr_en_o        (wr_en),
    .wr_slot_o      (wr_slot),
    .wr_key_o       (wr_key)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dirf_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (tok[i]),
      .tok_o     (tok[i+1]),
      .size_i    (size),
      .fill_i    (fill),
      .wr_en_i   (wr_en),
      .wr_slot_i (wr_slot),
      .wr_key_i  (wr_key)
    );
  end

endmodule

`default_nettype wire
